FILE: hdl/lane_pkg.sv
// shared types and constants for the label anchored number extractor
package lane_pkg;

  localparam int LEN_W = 6;
  localparam int CNT_W = 5;
  localparam int WIN_W = 9;
  localparam int VAL_W = 63;

  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] VALUE_LIMIT = VALUE_MAX / 10;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_FW0   = 8'hEF;
  localparam logic [7:0] CH_FW1   = 8'hBC;
  localparam logic [7:0] CH_FW2   = 8'h8C;

  localparam logic [1:0] REG_LABEL_LOW  = 2'd0;
  localparam logic [1:0] REG_LABEL_HIGH = 2'd1;
  localparam logic [1:0] REG_LABEL_LEN  = 2'd2;
  localparam logic [1:0] REG_GAP_LIMIT  = 2'd3;

  localparam logic [63:0] LABEL_LOW_RST  = 64'd182071828716774;
  localparam logic [63:0] LABEL_HIGH_RST = 64'd0;
  localparam logic [4:0]  LABEL_LEN_RST  = 5'd6;
  localparam logic [7:0]  GAP_LIMIT_RST  = 8'd60;

  typedef logic [15:0][7:0] label_t;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_NUMBER,
    PH_EF1,
    PH_EF2,
    PH_FOUND,
    PH_STOPPED
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } step_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] number_value;
  } result_t;

endpackage

FILE: hdl/lane_cell.sv
// one compare cell of the recent byte shift chain
module lane_cell #(
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       shift,
  input  lane_pkg::label_t           label,
  input  logic [lane_pkg::LEN_W-1:0] used_len,
  input  logic [7:0]                 din,
  output logic [7:0]                 dout,
  output logic                       eq
);

  logic [7:0]                 data;
  logic [lane_pkg::LEN_W-1:0] pos;
  logic                       active;
  logic [7:0]                 label_byte;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      data <= 8'h00;
    end else if (shift) begin
      data <= din;
    end
  end

  assign dout = data;

  // cell j compares its input, recent byte j (0 the incoming byte), with label byte len-1-j
  always_comb begin
    active = lane_pkg::LEN_W'(INDEX) < used_len;
    pos = used_len - lane_pkg::LEN_W'(INDEX) - lane_pkg::LEN_W'(1);
    label_byte = (pos < lane_pkg::LEN_W'(16)) ? label[pos[3:0]] : 8'h00;
    eq = !active || (din == label_byte);
  end

endmodule

FILE: hdl/lane_scan.sv
// scan phase, window, match counter and number accumulation
module lane_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  lane_pkg::step_t            step,
  input  logic                       match,
  input  logic [lane_pkg::LEN_W-1:0] used_len,
  input  logic [7:0]                 gap_limit,
  output logic                       shift,
  output lane_pkg::result_t          result
);

  lane_pkg::phase_t                  phase, phase_next;
  logic [lane_pkg::WIN_W-1:0]        window_left, window_left_next;
  logic [lane_pkg::CNT_W-1:0]        since_match, since_match_next;
  logic [lane_pkg::VAL_W-1:0]        value, value_next;
  logic [lane_pkg::VAL_W-1:0]        limit;
  logic [lane_pkg::VAL_W-1:0]        digit_ext;
  logic [3:0]                        digit_val;
  logic                              digit;
  logic [7:0]                        b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lane_pkg::PH_SEARCH;
      window_left <= '0;
      since_match <= '0;
      value       <= '0;
    end else if (accept) begin
      if (step.end_of_text) begin
        phase       <= lane_pkg::PH_SEARCH;
        window_left <= '0;
        since_match <= '0;
        value       <= '0;
      end else begin
        phase       <= phase_next;
        window_left <= window_left_next;
        since_match <= since_match_next;
        value       <= value_next;
      end
    end
  end

  always_comb begin
    b = step.text_byte;
    digit = (b >= lane_pkg::CH_ZERO) && (b <= lane_pkg::CH_NINE);
    digit_val = 4'(b - lane_pkg::CH_ZERO);
    digit_ext = lane_pkg::VAL_W'(digit_val);
    limit = (digit_val > 4'd7) ? lane_pkg::VALUE_LIMIT - lane_pkg::VAL_W'(1)
                               : lane_pkg::VALUE_LIMIT;
    phase_next = phase;
    window_left_next = window_left;
    since_match_next = since_match;
    value_next = value;
    shift = 1'b0;
    case (phase)
      lane_pkg::PH_SEARCH: begin
        if (b == 8'h00) begin
          phase_next = lane_pkg::PH_STOPPED;
        end else if ((window_left != '0) && digit) begin
          phase_next = lane_pkg::PH_NUMBER;
          value_next = digit_ext;
        end else begin
          shift = 1'b1;
          if (window_left != '0) begin
            window_left_next = window_left - lane_pkg::WIN_W'(1);
          end
          if (since_match < lane_pkg::COUNT_MAX) begin
            since_match_next = since_match + lane_pkg::CNT_W'(1);
          end
          if ((lane_pkg::LEN_W'(since_match_next) >= used_len) && match) begin
            window_left_next = lane_pkg::WIN_W'(gap_limit) + lane_pkg::WIN_W'(1);
            since_match_next = '0;
          end
        end
      end
      lane_pkg::PH_NUMBER: begin
        if (digit) begin
          if (value > limit) begin
            value_next = lane_pkg::VALUE_MAX;
          end else begin
            value_next = (value << 3) + (value << 1) + digit_ext;
          end
        end else if (b == lane_pkg::CH_COMMA) begin
          phase_next = lane_pkg::PH_NUMBER;
        end else if (b == lane_pkg::CH_FW0) begin
          phase_next = lane_pkg::PH_EF1;
        end else begin
          phase_next = lane_pkg::PH_FOUND;
        end
      end
      lane_pkg::PH_EF1: begin
        phase_next = (b == lane_pkg::CH_FW1) ? lane_pkg::PH_EF2 : lane_pkg::PH_FOUND;
      end
      lane_pkg::PH_EF2: begin
        phase_next = (b == lane_pkg::CH_FW2) ? lane_pkg::PH_NUMBER : lane_pkg::PH_FOUND;
      end
      default: begin
        phase_next = phase;
      end
    endcase
    result.found = (phase_next == lane_pkg::PH_NUMBER) || (phase_next == lane_pkg::PH_EF1) ||
                   (phase_next == lane_pkg::PH_EF2) || (phase_next == lane_pkg::PH_FOUND);
    result.number_value = result.found ? value_next : '0;
  end

endmodule

FILE: hdl/label_anchored_number_extract_core.sv
// top level of the label anchored number extractor
// Takes one text byte per cycle while ready: a row of LABEL_BYTES compare cells
// holds the latest bytes and checks the whole label against the incoming byte in
// the same cycle, so a label match and the number scan both finish per byte.
// Each tlast transfer yields one result (tuser = found, tdata = value). Results
// use an output register backed by one skid register; s_tready drops only while
// both hold results not yet taken. Registers are 64-bit at byte addresses 0, 8,
// 16 and 24, written only while the block is idle: a user rule, unchecked here.
module label_anchored_number_extract_core #(
  parameter int LABEL_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // number_value[62:0], zero bit 63
  output logic        m_tuser,   // found
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]                label_low;
  logic [63:0]                label_high;
  logic [4:0]                 label_length;
  logic [7:0]                 gap_limit;
  lane_pkg::label_t           label;
  logic [lane_pkg::LEN_W-1:0] used_len;
  logic                       cfg_write;

  logic                       accept;
  logic                       shift;
  logic                       match;
  lane_pkg::step_t            step;
  lane_pkg::result_t          result;
  lane_pkg::result_t          out_q;
  lane_pkg::result_t          skid_q;
  logic                       out_valid;
  logic                       skid_valid;
  logic                       push;
  logic                       pop;

  logic [7:0]                 cell_q [LABEL_BYTES];
  logic [LABEL_BYTES-1:0]     cell_eq;

  // configuration
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      label_low    <= lane_pkg::LABEL_LOW_RST;
      label_high   <= lane_pkg::LABEL_HIGH_RST;
      label_length <= lane_pkg::LABEL_LEN_RST;
      gap_limit    <= lane_pkg::GAP_LIMIT_RST;
    end else if (cfg_write) begin
      case (paddr[4:3])
        lane_pkg::REG_LABEL_LOW:  label_low    <= pwdata;
        lane_pkg::REG_LABEL_HIGH: label_high   <= pwdata;
        lane_pkg::REG_LABEL_LEN:  label_length <= pwdata[4:0];
        lane_pkg::REG_GAP_LIMIT:  gap_limit    <= pwdata[7:0];
        default: label_low <= label_low;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      lane_pkg::REG_LABEL_LOW:  prdata = label_low;
      lane_pkg::REG_LABEL_HIGH: prdata = label_high;
      lane_pkg::REG_LABEL_LEN:  prdata = 64'(label_length);
      lane_pkg::REG_GAP_LIMIT:  prdata = 64'(gap_limit);
      default: prdata = '0;
    endcase
  end

  assign label = {label_high, label_low};

  always_comb begin
    if (label_length == 5'd0) begin
      used_len = lane_pkg::LEN_W'(1);
    end else if (lane_pkg::LEN_W'(label_length) > lane_pkg::LEN_W'(LABEL_BYTES)) begin
      used_len = lane_pkg::LEN_W'(LABEL_BYTES);
    end else begin
      used_len = lane_pkg::LEN_W'(label_length);
    end
  end

  // input side
  assign s_tready = !skid_valid;
  assign accept = s_tvalid && s_tready;
  assign step.text_byte = s_tdata;
  assign step.end_of_text = s_tlast;

  // compare chain
  for (genvar j = 0; j < LABEL_BYTES; j++) begin : g_cell
    logic [7:0] din;
    if (j == 0) begin : g_head
      assign din = s_tdata;
    end else begin : g_link
      assign din = cell_q[j-1];
    end
    lane_cell #(
      .INDEX(j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (accept && s_tlast),
      .shift    (accept && shift),
      .label    (label),
      .used_len (used_len),
      .din      (din),
      .dout     (cell_q[j]),
      .eq       (cell_eq[j])
    );
  end

  assign match = &cell_eq;

  lane_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .step      (step),
    .match     (match),
    .used_len  (used_len),
    .gap_limit (gap_limit),
    .shift     (shift),
    .result    (result)
  );

  // output register with skid stage
  assign push = accept && s_tlast;
  assign pop = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_q      <= skid_q;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_q     <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid_q     <= result;
      skid_valid <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_q.found;
  assign m_tdata  = {1'b0, out_q.number_value};

  // checks
  a_value_needs_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 64'd0)
    else $error("result value nonzero without found");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while output register is empty");

  a_out_drops_on_take: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> $past(m_tready))
    else $error("result withdrawn before transfer");

endmodule

FILE: tb/number_extract_checker.sv
// checker for the label anchored number extractor: tracks config, predicts and compares results
module number_extract_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_results
);

  logic [63:0] label_lo;
  logic [63:0] label_hi;
  logic [4:0]  label_len_reg;
  logic [7:0]  gap_reg;

  logic [7:0]        history [16];
  logic [4:0]        since_match;
  logic [8:0]        window;
  lane_pkg::phase_t  phase;
  logic [62:0]       value_acc;

  lane_pkg::result_t expected_q [$];

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  task automatic restart_text();
    int i;
    for (i = 0; i < 16; i++) history[i] = 8'h00;
    since_match = '0;
    window = '0;
    phase = lane_pkg::PH_SEARCH;
    value_acc = '0;
  endtask

  function automatic logic [7:0] label_byte_at(input int i);
    if (i < 8) return label_lo[8*i +: 8];
    return label_hi[8*(i-8) +: 8];
  endfunction

  function automatic int effective_label_len();
    int n;
    n = int'(label_len_reg);
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  function automatic logic label_seen(input int len);
    int i;
    for (i = 0; i < len; i++)
      if (label_byte_at(i) != history[len-1-i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [62:0] append_digit(input logic [62:0] v, input logic [3:0] d);
    if (v > (lane_pkg::VALUE_MAX - {59'd0, d}) / 63'd10) return lane_pkg::VALUE_MAX;
    return v * 63'd10 + {59'd0, d};
  endfunction

  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic              is_digit;
    int                len;
    int                i;
    lane_pkg::result_t r;
    is_digit = (b >= lane_pkg::CH_ZERO) && (b <= lane_pkg::CH_NINE);
    case (phase)
      lane_pkg::PH_SEARCH: begin
        if (b == 8'h00) begin
          phase = lane_pkg::PH_STOPPED;
        end else if (window != 0 && is_digit) begin
          phase = lane_pkg::PH_NUMBER;
          value_acc = {55'd0, b - lane_pkg::CH_ZERO};
        end else begin
          len = effective_label_len();
          if (window != 0) window = window - 9'd1;
          for (i = 15; i > 0; i--) history[i] = history[i-1];
          history[0] = b;
          if (since_match < lane_pkg::COUNT_MAX) since_match = since_match + 5'd1;
          if (since_match >= len && label_seen(len)) begin
            window = {1'b0, gap_reg} + 9'd1;
            since_match = '0;
          end
        end
      end
      lane_pkg::PH_NUMBER: begin
        if (is_digit) value_acc = append_digit(value_acc, 4'(b - lane_pkg::CH_ZERO));
        else if (b != lane_pkg::CH_COMMA)
          phase = (b == lane_pkg::CH_FW0) ? lane_pkg::PH_EF1 : lane_pkg::PH_FOUND;
      end
      lane_pkg::PH_EF1:
        phase = (b == lane_pkg::CH_FW1) ? lane_pkg::PH_EF2 : lane_pkg::PH_FOUND;
      lane_pkg::PH_EF2:
        phase = (b == lane_pkg::CH_FW2) ? lane_pkg::PH_NUMBER : lane_pkg::PH_FOUND;
      default: ;
    endcase
    if (last) begin
      r.found = phase inside {lane_pkg::PH_NUMBER, lane_pkg::PH_EF1, lane_pkg::PH_EF2,
                              lane_pkg::PH_FOUND};
      r.number_value = r.found ? value_acc : '0;
      expected_q.push_back(r);
      restart_text();
    end
  endtask

  task automatic check_result();
    lane_pkg::result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing expected", m_tdata, 64'd0);
    end else begin
      want = expected_q.pop_front();
      if (m_tuser !== want.found)
        report_mismatch("found", {63'd0, m_tuser}, {63'd0, want.found});
      if (m_tdata !== {1'b0, want.number_value})
        report_mismatch("number_value", m_tdata, {1'b0, want.number_value});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      label_lo = lane_pkg::LABEL_LOW_RST;
      label_hi = lane_pkg::LABEL_HIGH_RST;
      label_len_reg = lane_pkg::LABEL_LEN_RST;
      gap_reg = lane_pkg::GAP_LIMIT_RST;
      restart_text();
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          lane_pkg::REG_LABEL_LOW:  label_lo = pwdata;
          lane_pkg::REG_LABEL_HIGH: label_hi = pwdata;
          lane_pkg::REG_LABEL_LEN:  label_len_reg = pwdata[4:0];
          lane_pkg::REG_GAP_LIMIT:  gap_reg = pwdata[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_result();
    end
    pending_results = expected_q.size();
  end

endmodule

FILE: tb/tb_label_anchored_number_extract_core.sv
// testbench top for the label anchored number extractor: stimulus, register setup and verdict
module tb_label_anchored_number_extract_core;

  localparam int QUIET_LIMIT = 1000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending_results;
  int          quiet_cycles = 0;
  bit          idling_on = 1'b1;

  logic [127:0] label_bits;
  int           lab_len;
  int           gap_now;
  logic [7:0]   text_q [$];

  label_anchored_number_extract_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  number_extract_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int random_gap();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int stall;
    m_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = random_gap();
      end
    end
  end

  function automatic int used_len(input int n);
    if (n == 0) return 1;
    if (n > 16) return 16;
    return n;
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b >= lane_pkg::CH_ZERO && b <= lane_pkg::CH_NINE) b = b + 8'h10;
    return b;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_setting(input logic [127:0] bits, input int len, input int gap);
    write_reg(lane_pkg::REG_LABEL_LOW, bits[63:0]);
    write_reg(lane_pkg::REG_LABEL_HIGH, bits[127:64]);
    write_reg(lane_pkg::REG_LABEL_LEN, 64'(len));
    write_reg(lane_pkg::REG_GAP_LIMIT, 64'(gap));
    label_bits = bits;
    lab_len = len;
    gap_now = gap;
  endtask

  task automatic send_text();
    int k;
    for (k = 0; k < text_q.size(); k++) begin
      repeat (random_gap()) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
      @(negedge clk);
      s_tvalid <= 1'b1;
      s_tdata <= text_q[k];
      s_tlast <= (k == text_q.size() - 1);
      do @(posedge clk); while (!s_tready);
    end
  endtask

  // first byte sits in the highest used byte of seq
  task automatic send_bytes(input logic [127:0] seq, input int n);
    int k;
    text_q.delete();
    for (k = 0; k < n; k++) text_q.push_back(seq[8*(n-1-k) +: 8]);
    send_text();
  endtask

  task automatic add_label();
    int i;
    for (i = 0; i < used_len(lab_len); i++) text_q.push_back(label_bits[8*i +: 8]);
  endtask

  task automatic build_text();
    int kind;
    int n;
    int g;
    int i;
    int sep;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 4)) text_q.push_back(filler_byte());
      add_label();
      sep = $urandom_range(0, 9);
      if (sep < 7) g = $urandom_range(0, (gap_now < 4) ? gap_now : 4);
      else if (sep < 9) g = gap_now;
      else g = gap_now + 1;
      repeat (g) text_q.push_back(filler_byte());
      // second label restarts the window
      if (kind < 22) add_label();
      if (kind >= 86 && kind < 92) text_q.push_back(8'h00);
      if (kind < 95) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          text_q.push_back(lane_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          sep = $urandom_range(0, 19);
          if (i < n - 1) begin
            if (sep < 3) begin
              text_q.push_back(lane_pkg::CH_COMMA);
            end else if (sep == 3) begin
              text_q.push_back(lane_pkg::CH_FW0);
              text_q.push_back(lane_pkg::CH_FW1);
              text_q.push_back(lane_pkg::CH_FW2);
            end else if (sep == 4) begin
              text_q.push_back(lane_pkg::CH_FW0);
              text_q.push_back(filler_byte());
            end else if (sep == 5) begin
              text_q.push_back(lane_pkg::CH_FW0);
              text_q.push_back(lane_pkg::CH_FW1);
              text_q.push_back(filler_byte());
            end
          end
        end
      end
      repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int           ph;
    int           len;
    int           gap;
    int           pos;
    int           sent;
    logic [127:0] bits;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    label_bits = {lane_pkg::LABEL_HIGH_RST, lane_pkg::LABEL_LOW_RST};
    lab_len = int'(lane_pkg::LABEL_LEN_RST);
    gap_now = int'(lane_pkg::GAP_LIMIT_RST);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    repeat (3) begin
      build_text();
      send_text();
    end
    settle();

    // one byte label, zero length read as one, window of a single byte
    apply_setting({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF41}, 0, 0);
    send_bytes({"A1,2", lane_pkg::CH_FW0, lane_pkg::CH_FW1, lane_pkg::CH_FW2, "3x9"}, 10);
    send_bytes({"A5", lane_pkg::CH_FW0, lane_pkg::CH_FW1, "Z"}, 5);
    send_bytes("A 7", 3);
    send_bytes({8'h00, "A8"}, 3);
    send_bytes(8'hFF, 1);
    send_bytes("AA6", 3);
    send_bytes("A3", 2);

    for (ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin len = 16; gap = 255; end
        1: begin len = 31; gap = 0; end
        2: begin len = 0; gap = $urandom_range(0, 8); end
        3: begin len = 1; gap = $urandom_range(0, 8); end
        default: begin
          len = $urandom_range(1, 16);
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        end
      endcase
      bits = {$urandom, $urandom, $urandom, $urandom};
      for (pos = 0; pos < used_len(len); pos++)
        if (bits[8*pos +: 8] == 8'h00) bits[8*pos +: 8] = 8'h5A;
      // label holding a zero byte never matches
      if (ph == 4) bits[8*$urandom_range(0, used_len(len) - 1) +: 8] = 8'h00;
      apply_setting(bits, len, gap);
      idling_on = (ph % 3 != 1);
      sent = 0;
      while (sent < 100) begin
        build_text();
        send_text();
        sent += text_q.size();
      end
    end
    settle();

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
